@@ sv/tbrc_pkg.sv @@
// tbrc_pkg: types, command and refusal codes and per-bell helpers for the
// two-bell relay controller core. No dependencies.

package tbrc_pkg;

  // command codes of the input word
  typedef enum logic [2:0] {
    CMD_TICK    = 3'd0,
    CMD_ON      = 3'd1,
    CMD_ON_TIMED = 3'd2,
    CMD_OFF     = 3'd3,
    CMD_PRESS   = 3'd4,
    CMD_RELEASE = 3'd5,
    CMD_BLOCK   = 3'd6,
    CMD_UNBLOCK = 3'd7
  } cmd_e;

  // refusal codes of the result word
  typedef enum logic [1:0] {
    REF_NONE     = 2'd0,
    REF_DISABLED = 2'd1,
    REF_BLOCKED  = 2'd2,
    REF_NO_TIME  = 2'd3
  } refusal_e;

  // configuration register indexes
  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned CfgDataW = 8;
  localparam logic [CfgIdxW-1:0] CFG_BELLS_IN_USE = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_INERTIA_ONE  = 2'd1;
  localparam logic [CfgIdxW-1:0] CFG_INERTIA_TWO  = 2'd2;

  localparam int unsigned InDataW  = 40;
  localparam int unsigned OutDataW = 8;
  localparam int unsigned InertLenW = 18;
  localparam logic [InertLenW-1:0] MsPerSecond = 18'd1000;

  // accepted input word
  typedef struct packed {
    logic        time_confirmed;
    logic [31:0] ring_ms;
    logic        bell_index;
    logic [2:0]  command;
  } in_word_t;

  // result word
  typedef struct packed {
    refusal_e   refusal;
    logic       preempt_special;
    logic       any_inertia;
    logic [1:0] lamp_bits;
    logic [1:0] relay_bits;
  } out_word_t;

  // state of one bell
  typedef struct packed {
    logic                 on;
    logic [31:0]          ring_start;
    logic [31:0]          ring_len;
    logic                 inert;
    logic [31:0]          inert_start;
    logic [InertLenW-1:0] inert_len;
    logic                 hold;
  } bell_t;

  // silence a bell without inertia
  function automatic bell_t bell_drop(bell_t b);
    bell_t r;
    r            = b;
    r.on         = 1'b0;
    r.ring_start = '0;
    r.ring_len   = '0;
    return r;
  endfunction

  // switch a silent bell on, stopping its inertia
  function automatic bell_t bell_start(bell_t b, logic [31:0] now);
    bell_t r;
    r             = b;
    r.inert       = 1'b0;
    r.inert_start = '0;
    r.inert_len   = '0;
    r.on          = 1'b1;
    r.ring_start  = now;
    r.ring_len    = '0;
    return r;
  endfunction

  // switch a ringing bell off and start its inertia timer
  function automatic bell_t bell_stop(bell_t b, logic [31:0] now, logic [7:0] secs);
    bell_t r;
    r             = bell_drop(b);
    r.inert       = 1'b1;
    r.inert_start = now;
    r.inert_len   = {{(InertLenW-8){1'b0}}, secs} * MsPerSecond;
    return r;
  endfunction

endpackage

@@ sv/two_bell_relay_controller_core.sv @@
// two_bell_relay_controller_core: command decoder and state for two bell relays.
// Depends on tbrc_pkg.
//
// Usage
//   s_axis: command words (tick, on, timed on, off, manual press/release,
//   block, unblock). m_axis: one status word per command word (relays,
//   lamps, inertia flag, preempt flag, refusal code).
//   cfg: plain write port, index 0 bells in use, 1 and 2 inertia seconds
//   of bell one and two; writes to other indexes are ignored.
// Timing
//   A word is held in an input register, the whole command is evaluated
//   combinationally and its status lands in the output register, from
//   which it can be accepted. One word per cycle sustained while
//   m_axis_tready stays high; the single stage sets it.
// Reset
//   All bells silent, no inertia, not blocked, millisecond count zero,
//   two bells in use and zero inertia seconds.
// Stall
//   While m_axis_tready is low the status word holds; one more command word
//   is taken into the input register, then s_axis_tready drops.

module two_bell_relay_controller_core #(
  parameter int unsigned BLINK_HALF_PERIOD_MS = 500
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // command: [2:0] command, [3] bell_index, [35:4] ring_ms,
  // [36] time_confirmed, [39:37] zero
  input  logic [tbrc_pkg::InDataW-1:0]   s_axis_tdata,
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  // status: [1:0] relay_bits, [3:2] lamp_bits, [4] any_inertia,
  // [5] preempt_special, [7:6] refusal
  output logic [tbrc_pkg::OutDataW-1:0]  m_axis_tdata,
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  // configuration writes
  input  logic                           cfg_we_i,
  input  logic [tbrc_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  logic [tbrc_pkg::CfgDataW-1:0]  cfg_data_i
);
  import tbrc_pkg::*;

  localparam int unsigned BlinkW =
    (BLINK_HALF_PERIOD_MS > 1) ? $clog2(BLINK_HALF_PERIOD_MS) : 1;
  localparam logic [BlinkW-1:0] BlinkLast = BlinkW'(BLINK_HALF_PERIOD_MS - 1);

  // configuration
  logic [1:0] bells_in_use_q;
  logic [7:0] secs_q [2];
  logic [1:0] enabled;

  // handshake and word registers
  logic      in_valid_q, out_valid_q;
  in_word_t  in_q;
  out_word_t out_q, out_d;
  logic      s_take, adv;

  // controller state
  bell_t             bell_q [2];
  bell_t             bell_d [2];
  logic [31:0]       now_q, now_d;
  logic [BlinkW-1:0] blink_cnt_q, blink_cnt_d;
  logic              phase_q, phase_d;
  logic              blocked_q, blocked_d;

  cmd_e cmd;
  logic sel;

  assign s_take        = s_axis_tvalid & s_axis_tready;
  assign adv           = in_valid_q & (~out_valid_q | m_axis_tready);
  assign s_axis_tready = ~in_valid_q | adv;
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_q;

  assign cmd = cmd_e'(in_q.command);
  assign sel = in_q.bell_index;

  // bell k (one based) is enabled when k <= bells in use
  assign enabled[0] = (bells_in_use_q >= 2'd1);
  assign enabled[1] = (bells_in_use_q >= 2'd2);

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bells_in_use_q <= 2'd2;
      secs_q[0]      <= '0;
      secs_q[1]      <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_BELLS_IN_USE: bells_in_use_q <= cfg_data_i[1:0];
        CFG_INERTIA_ONE:  secs_q[0] <= cfg_data_i;
        CFG_INERTIA_TWO:  secs_q[1] <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // command evaluation
  always_comb begin
    bell_d      = bell_q;
    now_d       = now_q;
    blink_cnt_d = blink_cnt_q;
    phase_d     = phase_q;
    blocked_d   = blocked_q;
    out_d       = '0;
    out_d.refusal = REF_NONE;

    unique case (cmd)
      CMD_TICK: begin
        now_d = now_q + 32'd1;
        // blink phase follows (now / half period) mod 2, restarting at wrap
        if (now_d == '0) begin
          blink_cnt_d = '0;
          phase_d     = 1'b0;
        end else if (blink_cnt_q == BlinkLast) begin
          blink_cnt_d = '0;
          phase_d     = ~phase_q;
        end else begin
          blink_cnt_d = blink_cnt_q + BlinkW'(1);
        end
        for (int i = 0; i < 2; i++) begin
          // block drops bells, otherwise held switches re-arm silent bells
          if (blocked_q) begin
            if (bell_d[i].on) bell_d[i] = bell_drop(bell_d[i]);
          end else if (bell_d[i].hold && !bell_d[i].on && enabled[i]) begin
            bell_d[i] = bell_start(bell_d[i], now_d);
            out_d.preempt_special = 1'b1;
          end
          // inertia expiry
          if (bell_d[i].inert &&
              ((now_d - bell_d[i].inert_start) >=
               {{(32-InertLenW){1'b0}}, bell_d[i].inert_len}))
            bell_d[i].inert = 1'b0;
          // timed ring expiry
          if (!blocked_q && bell_d[i].on && !bell_d[i].hold &&
              (bell_d[i].ring_len != '0) &&
              ((now_d - bell_d[i].ring_start) >= bell_d[i].ring_len))
            bell_d[i] = bell_stop(bell_d[i], now_d, secs_q[i]);
        end
      end
      CMD_ON, CMD_ON_TIMED: begin
        if (!enabled[sel]) begin
          out_d.refusal = REF_DISABLED;
        end else if (blocked_q) begin
          out_d.refusal = REF_BLOCKED;
        end else if (!in_q.time_confirmed) begin
          out_d.refusal = REF_NO_TIME;
        end else if (!bell_d[sel].on) begin
          bell_d[sel] = bell_start(bell_d[sel], now_q);
          out_d.preempt_special = 1'b1;
        end
        // timed form stores its duration whatever the outcome
        if (cmd == CMD_ON_TIMED) begin
          bell_d[sel].ring_start = now_q;
          bell_d[sel].ring_len   = in_q.ring_ms;
        end
      end
      CMD_OFF: begin
        if (bell_d[sel].on) bell_d[sel] = bell_stop(bell_d[sel], now_q, secs_q[sel]);
      end
      CMD_PRESS: begin
        if (enabled[sel]) begin
          bell_d[sel].hold = 1'b1;
          if (blocked_q) begin
            out_d.refusal = REF_BLOCKED;
          end else if (!bell_d[sel].on) begin
            bell_d[sel] = bell_start(bell_d[sel], now_q);
            out_d.preempt_special = 1'b1;
          end
        end else begin
          bell_d[sel].hold = 1'b0;
          out_d.refusal = REF_DISABLED;
        end
      end
      CMD_RELEASE: begin
        bell_d[sel].hold = 1'b0;
        if (bell_d[sel].on) bell_d[sel] = bell_stop(bell_d[sel], now_q, secs_q[sel]);
      end
      CMD_BLOCK: begin
        if (!blocked_q) begin
          blocked_d = 1'b1;
          for (int i = 0; i < 2; i++) begin
            if (bell_d[i].on) bell_d[i] = bell_drop(bell_d[i]);
          end
        end
      end
      CMD_UNBLOCK: blocked_d = 1'b0;
      default: ;
    endcase

    // relay, lamp and inertia status after the command
    for (int i = 0; i < 2; i++) begin
      out_d.relay_bits[i] = bell_d[i].on;
      out_d.lamp_bits[i]  = bell_d[i].on | (bell_d[i].inert & ~phase_d);
    end
    out_d.any_inertia = bell_d[0].inert | bell_d[1].inert;
  end

  // state registers, updated when a word is evaluated
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 2; i++) bell_q[i] <= '0;
      now_q       <= '0;
      blink_cnt_q <= '0;
      phase_q     <= 1'b0;
      blocked_q   <= 1'b0;
    end else if (adv) begin
      bell_q      <= bell_d;
      now_q       <= now_d;
      blink_cnt_q <= blink_cnt_d;
      phase_q     <= phase_d;
      blocked_q   <= blocked_d;
    end
  end

  // input and output word valid flags
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      in_valid_q  <= s_take | (in_valid_q & ~adv);
      out_valid_q <= adv | (out_valid_q & ~m_axis_tready);
    end
  end

  // word payload registers
  always_ff @(posedge clk_i) begin
    if (s_take) in_q <= in_word_t'(s_axis_tdata[36:0]);
    if (adv)    out_q <= out_d;
  end

endmodule

@@ verif/tb_two_bell_relay_controller_core.sv @@
// tb_two_bell_relay_controller_core: self-checking bench for the two-bell relay
// controller core, with a cycle-free behavioral model of the bells predicting
// every status word. Depends on tbrc_pkg and two_bell_relay_controller_core.
`timescale 1ns / 100ps

module tb_two_bell_relay_controller_core;
  import tbrc_pkg::*;

  localparam int unsigned BLINK_HALF_MS = 500;
  localparam int unsigned MS_PER_SEC    = 1000;
  localparam int unsigned HOLD_LEN      = 300;
  localparam int unsigned STALL_LIMIT   = 4000;

  logic                clk_i;
  logic                rst_ni = 1'b0;
  logic [InDataW-1:0]  s_axis_tdata = '0;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  logic [OutDataW-1:0] m_axis_tdata;
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  logic                cfg_we_i = 1'b0;
  logic [CfgIdxW-1:0]  cfg_idx_i = '0;
  logic [CfgDataW-1:0] cfg_data_i = '0;

  // idle odds in percent, hold-off request and bookkeeping
  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;
  logic        hold_ask = 1'b0;
  int unsigned idle_cycles = 0;
  int unsigned mismatches = 0;
  out_word_t   status_due[$];

  // model copy of the configuration
  logic [1:0] bells_cfg = 2'd2;
  logic [7:0] inert_secs [2] = '{8'd0, 8'd0};

  // model copy of the bell state
  logic [31:0]          ms_count = '0;
  logic [1:0]           ringing = '0;
  logic [1:0]           inert_run = '0;
  logic [1:0]           held = '0;
  logic                 blocked_q = 1'b0;
  logic                 preempt_now;
  logic [31:0]          ring_t0 [2] = '{32'd0, 32'd0};
  logic [31:0]          ring_dur [2] = '{32'd0, 32'd0};
  logic [31:0]          inert_t0 [2] = '{32'd0, 32'd0};
  logic [InertLenW-1:0] inert_dur [2] = '{'0, '0};

  two_bell_relay_controller_core #(
    .BLINK_HALF_PERIOD_MS(BLINK_HALF_MS)
  ) dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_data_i   (cfg_data_i)
  );

  // 2 ns clock
  always begin
    clk_i = 1'b0;
    #1;
    clk_i = 1'b1;
    #1;
  end

  // ---------------------------------------------------------------------------
  // bell model

  function automatic logic bell_enabled(int b);
    return (b + 1) <= int'(bells_cfg);
  endfunction

  // silence without inertia
  function automatic void quiet_bell(int b);
    ringing[b]  = 1'b0;
    ring_t0[b]  = '0;
    ring_dur[b] = '0;
  endfunction

  // switch on with enable, block and time checks
  function automatic refusal_e ring_bell(int b, logic manual, logic tc);
    if (!bell_enabled(b)) return REF_DISABLED;
    if (blocked_q) return REF_BLOCKED;
    if (!tc && !manual) return REF_NO_TIME;
    if (!ringing[b]) begin
      inert_run[b] = 1'b0;
      inert_t0[b]  = '0;
      inert_dur[b] = '0;
      ringing[b]   = 1'b1;
      ring_t0[b]   = ms_count;
      ring_dur[b]  = '0;
      preempt_now  = 1'b1;
    end
    return REF_NONE;
  endfunction

  // switch off a ringing bell and start its inertia
  function automatic void silence_bell(int b);
    if (ringing[b]) begin
      quiet_bell(b);
      inert_run[b] = 1'b1;
      inert_t0[b]  = ms_count;
      inert_dur[b] = InertLenW'(inert_secs[b]) * InertLenW'(MS_PER_SEC);
    end
  endfunction

  // advance the bells by one command and give the status word it produces
  function automatic out_word_t apply_command(in_word_t w);
    out_word_t   st;
    refusal_e    why;
    int          b;
    int          i;
    logic [31:0] elapsed;
    logic [31:0] blink_phase;
    logic [1:0]  lamp;
    b           = int'(w.bell_index);
    why         = REF_NONE;
    preempt_now = 1'b0;
    case (w.command)
      CMD_TICK: begin
        ms_count = ms_count + 32'd1;
        for (i = 0; i < 2; i++) begin
          if (blocked_q) begin
            if (ringing[i]) quiet_bell(i);
          end else if (held[i] && !ringing[i]) begin
            void'(ring_bell(i, 1'b1, w.time_confirmed));
          end
        end
        for (i = 0; i < 2; i++) begin
          elapsed = ms_count - inert_t0[i];
          if (inert_run[i] && elapsed >= 32'(inert_dur[i])) inert_run[i] = 1'b0;
        end
        if (!blocked_q) begin
          for (i = 0; i < 2; i++) begin
            elapsed = ms_count - ring_t0[i];
            if (ringing[i] && !held[i] && ring_dur[i] != 0 && elapsed >= ring_dur[i])
              silence_bell(i);
          end
        end
      end
      CMD_ON: why = ring_bell(b, 1'b0, w.time_confirmed);
      CMD_ON_TIMED: begin
        why         = ring_bell(b, 1'b0, w.time_confirmed);
        ring_t0[b]  = ms_count;
        ring_dur[b] = w.ring_ms;
      end
      CMD_OFF: silence_bell(b);
      CMD_PRESS: begin
        if (bell_enabled(b)) begin
          held[b] = 1'b1;
          if (blocked_q) why = REF_BLOCKED;
          else why = ring_bell(b, 1'b1, w.time_confirmed);
        end else begin
          held[b] = 1'b0;
          why     = REF_DISABLED;
        end
      end
      CMD_RELEASE: begin
        held[b] = 1'b0;
        silence_bell(b);
      end
      CMD_BLOCK: begin
        if (!blocked_q) begin
          blocked_q = 1'b1;
          for (i = 0; i < 2; i++) if (ringing[i]) quiet_bell(i);
        end
      end
      default: blocked_q = 1'b0;
    endcase
    // lamps: steady while ringing, blinking during inertia
    blink_phase = ms_count / BLINK_HALF_MS;
    for (i = 0; i < 2; i++) begin
      if (ringing[i]) lamp[i] = 1'b1;
      else if (inert_run[i]) lamp[i] = ~blink_phase[0];
      else lamp[i] = 1'b0;
    end
    st.relay_bits      = ringing;
    st.lamp_bits       = lamp;
    st.any_inertia     = |inert_run;
    st.preempt_special = preempt_now;
    st.refusal         = why;
    return st;
  endfunction

  // ---------------------------------------------------------------------------
  // stimulus helpers

  function automatic in_word_t cmd_word(cmd_e c, logic bell, logic [31:0] dur, logic tc);
    in_word_t w;
    w.command        = c;
    w.bell_index     = bell;
    w.ring_ms        = dur;
    w.time_confirmed = tc;
    return w;
  endfunction

  // mostly ticks, short timed rings, rare blocks
  function automatic in_word_t random_command();
    int unsigned pick;
    cmd_e        c;
    logic [31:0] dur;
    pick = $urandom_range(99);
    if (pick < 45) c = CMD_TICK;
    else if (pick < 55) c = CMD_ON;
    else if (pick < 66) c = CMD_ON_TIMED;
    else if (pick < 75) c = CMD_OFF;
    else if (pick < 83) c = CMD_PRESS;
    else if (pick < 91) c = CMD_RELEASE;
    else if (pick < 95) c = CMD_BLOCK;
    else c = CMD_UNBLOCK;
    case ($urandom_range(7))
      0: dur = '0;
      1: dur = $urandom;
      2: dur = '1;
      default: dur = $urandom_range(40, 1);
    endcase
    return cmd_word(c, 1'($urandom_range(1)), dur, $urandom_range(99) < 80);
  endfunction

  // offer one word, wait for the handshake and queue its predicted status;
  // called and returning at a falling edge with tvalid left high
  task automatic send_word(in_word_t w);
    if ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      do @(negedge clk_i); while ($urandom_range(99) < send_idle_pct);
    end
    s_axis_tdata  <= {{(InDataW - $bits(in_word_t)){1'b0}}, w};
    s_axis_tvalid <= 1'b1;
    do @(posedge clk_i); while (!s_axis_tready);
    status_due.push_back(apply_command(w));
    @(negedge clk_i);
  endtask

  // stop offering and wait until every status word is back
  task automatic wait_quiet();
    s_axis_tvalid <= 1'b0;
    while (status_due.size() != 0) @(negedge clk_i);
    repeat (6) @(negedge clk_i);
  endtask

  // write all three registers on consecutive cycles, block idle
  task automatic set_config(logic [1:0] bells, logic [7:0] s_one, logic [7:0] s_two);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= CFG_BELLS_IN_USE;
    cfg_data_i <= {{(CfgDataW - 2){1'b0}}, bells};
    @(negedge clk_i);
    cfg_idx_i  <= CFG_INERTIA_ONE;
    cfg_data_i <= s_one;
    @(negedge clk_i);
    cfg_idx_i  <= CFG_INERTIA_TWO;
    cfg_data_i <= s_two;
    @(negedge clk_i);
    cfg_we_i      <= 1'b0;
    bells_cfg     = bells;
    inert_secs[0] = s_one;
    inert_secs[1] = s_two;
  endtask

  // ---------------------------------------------------------------------------
  // tests

  // every command and the special cases, reset configuration
  task automatic test_directed();
    in_word_t seq [$];
    seq = {
      cmd_word(CMD_ON,       1'b0, 32'd0,  1'b0),  // time not confirmed
      cmd_word(CMD_ON,       1'b0, 32'd0,  1'b1),
      cmd_word(CMD_ON,       1'b0, 32'd0,  1'b1),  // already ringing
      cmd_word(CMD_ON_TIMED, 1'b1, 32'd3,  1'b1),
      cmd_word(CMD_TICK,     1'b0, 32'd0,  1'b0),
      cmd_word(CMD_TICK,     1'b0, 32'd0,  1'b1),
      cmd_word(CMD_TICK,     1'b1, 32'd0,  1'b0),  // timed ring ends
      cmd_word(CMD_TICK,     1'b0, 32'd0,  1'b1),  // zero inertia ends
      cmd_word(CMD_OFF,      1'b0, 32'd0,  1'b0),
      cmd_word(CMD_OFF,      1'b0, 32'd0,  1'b0),  // off of a silent bell
      cmd_word(CMD_PRESS,    1'b1, 32'd0,  1'b0),  // manual skips time check
      cmd_word(CMD_ON_TIMED, 1'b1, 32'd1,  1'b0),  // refused, length still stored
      cmd_word(CMD_TICK,     1'b0, 32'd0,  1'b0),  // held bell stays on
      cmd_word(CMD_BLOCK,    1'b0, 32'd0,  1'b0),
      cmd_word(CMD_ON,       1'b0, 32'd0,  1'b1),  // blocked
      cmd_word(CMD_PRESS,    1'b0, 32'd0,  1'b1),  // blocked, hold kept
      cmd_word(CMD_BLOCK,    1'b1, 32'd0,  1'b1),  // block when blocked
      cmd_word(CMD_TICK,     1'b0, 32'd0,  1'b1),
      cmd_word(CMD_UNBLOCK,  1'b0, 32'd0,  1'b0),
      cmd_word(CMD_TICK,     1'b1, 32'd0,  1'b0),  // held bells ring again
      cmd_word(CMD_RELEASE,  1'b1, 32'd0,  1'b0),
      cmd_word(CMD_RELEASE,  1'b0, 32'hFFFF_FFFF, 1'b1),
      cmd_word(CMD_UNBLOCK,  1'b1, 32'd0,  1'b1),  // unblock when not blocked
      cmd_word(CMD_ON_TIMED, 1'b0, 32'hFFFF_FFFF, 1'b1),
      cmd_word(CMD_ON_TIMED, 1'b1, 32'd0,  1'b1)   // zero length means untimed
    };
    foreach (seq[k]) send_word(seq[k]);
    wait_quiet();
  endtask

  // random words under changing settings and idle patterns
  task automatic test_config_sweep();
    int         k;
    logic [7:0] s_one;
    logic [7:0] s_two;
    for (k = 0; k < 9; k++) begin
      if (k == 3) begin
        send_idle_pct = 76;
        recv_idle_pct = 11;
      end else if (k == 6) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      case (k % 3)
        0: begin
          s_one = 8'd0;
          s_two = 8'd255;
        end
        1: begin
          s_one = 8'd255;
          s_two = 8'd0;
        end
        default: begin
          s_one = 8'($urandom_range(255));
          s_two = 8'd0;
        end
      endcase
      set_config(2'(k % 4), s_one, s_two);
      repeat (40) send_word(random_command());
      wait_quiet();
    end
  endtask

  // long receiver hold-off while words keep coming
  task automatic test_backpressure();
    set_config(2'd3, 8'd0, 8'd1);
    @(posedge clk_i);
    hold_ask = 1'b1;
    @(negedge clk_i);
    repeat (40) send_word(random_command());
    wait_quiet();
  endtask

  // inertia runs long enough for the lamps to blink in both phases
  task automatic test_inertia_blink();
    set_config(2'd2, 8'd1, 8'd255);
    send_word(cmd_word(CMD_ON,  1'b0, 32'd0, 1'b1));
    send_word(cmd_word(CMD_ON,  1'b1, 32'd0, 1'b1));
    send_word(cmd_word(CMD_OFF, 1'b0, 32'd0, 1'b0));
    send_word(cmd_word(CMD_OFF, 1'b1, 32'd0, 1'b0));
    repeat (560) send_word(cmd_word(CMD_TICK, 1'b0, 32'd0, 1'($urandom_range(1))));
    // switching on during inertia stops it
    send_word(cmd_word(CMD_ON,  1'b1, 32'd0, 1'b1));
    send_word(cmd_word(CMD_OFF, 1'b1, 32'd0, 1'b1));
    send_word(cmd_word(CMD_TICK, 1'b1, 32'd0, 1'b0));
    wait_quiet();
  endtask

  // ---------------------------------------------------------------------------
  // receiver: random stalls, or a counted hold-off on request
  initial begin
    forever begin
      @(negedge clk_i);
      if (hold_ask) begin
        hold_ask = 1'b0;
        m_axis_tready <= 1'b0;
        repeat (HOLD_LEN) @(negedge clk_i);
      end
      m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  function automatic void check_field(string name, logic [7:0] want, logic [7:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatches++;
    end
  endfunction

  // compare each status word with the oldest prediction
  always @(posedge clk_i) begin
    out_word_t got;
    out_word_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got = m_axis_tdata;
      if (status_due.size() == 0) begin
        $error("status word %h with none predicted", m_axis_tdata);
        mismatches++;
      end else begin
        want = status_due.pop_front();
        check_field("relay_bits", 8'(want.relay_bits), 8'(got.relay_bits));
        check_field("lamp_bits", 8'(want.lamp_bits), 8'(got.lamp_bits));
        check_field("any_inertia", 8'(want.any_inertia), 8'(got.any_inertia));
        check_field("preempt_special", 8'(want.preempt_special), 8'(got.preempt_special));
        check_field("refusal", 8'(want.refusal), 8'(got.refusal));
      end
    end
  end

  // watchdog on cycles without any handshake
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // main sequence
  initial begin
    send_idle_pct = 11;
    recv_idle_pct = 76;
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);
    test_directed();
    test_config_sweep();
    test_backpressure();
    test_inertia_blink();
    if (status_due.size() != 0) begin
      $error("%0d status words never arrived", status_due.size());
      mismatches++;
    end
    if (mismatches == 0) $display("Simulation PASSED");
    else $display("Simulation FAILED");
    $finish;
  end

endmodule
